// File: sv/mbap_pkg.sv
// Shared types and constants for the MBAP request deframer.
package mbap_pkg;

  localparam int unsigned HDR_BYTES = 6;
  localparam int unsigned MIN_LEN   = 2;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned MAX_W     = 17;

  localparam logic [MAX_W-1:0] MAX_FRAME_RESET = 17'd260;

  // Operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_PROTO_ID  = 2'd1;
  localparam logic [1:0] ERR_LEN_SHORT = 2'd2;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

  // One result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [15:0] trans_id;
    logic [15:0] frame_length;
    logic [1:0]  error_code;
  } res_t;

endpackage

// File: sv/mbap_parser.sv
// Per-byte MBAP header capture, header check and payload marking.
module mbap_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mbap_pkg::MAX_W-1:0]    cfg_data,
  input  logic                          in_fire,
  input  logic                          operation,
  input  logic [7:0]                    rx_byte,
  output logic                          res_valid,
  output mbap_pkg::res_t                res
);

  logic [mbap_pkg::MAX_W-1:0] max_frame_bytes;
  logic [mbap_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [47:0]                header_store, header_store_next;
  logic                       closed, closed_next;

  logic [47:0]                hdr_new;
  logic [15:0]                prot_field;
  logic [15:0]                len;
  logic [mbap_pkg::POS_W:0]   frame_total;
  logic [mbap_pkg::POS_W:0]   pos_plus1;
  logic                       in_header;
  logic                       hdr_done;
  logic                       last;

  // Field extraction on the header as it stands after this byte
  assign in_header   = byte_position < mbap_pkg::POS_W'(mbap_pkg::HDR_BYTES);
  assign hdr_new     = in_header ? {header_store[39:0], rx_byte} : header_store;
  assign hdr_done    = in_header &&
                       (byte_position == mbap_pkg::POS_W'(mbap_pkg::HDR_BYTES - 1));
  assign prot_field  = hdr_new[31:16];
  assign len         = hdr_new[15:0];
  assign frame_total = (mbap_pkg::POS_W+1)'(mbap_pkg::HDR_BYTES) + {2'b00, len};
  assign pos_plus1   = {1'b0, byte_position} + 1'b1;
  assign last        = pos_plus1 >= frame_total;

  // Next state and result
  always_comb begin
    byte_position_next = byte_position;
    header_store_next  = header_store;
    closed_next        = closed;
    res_valid          = 1'b0;
    res.kind           = mbap_pkg::KIND_PAYLOAD;
    res.data_byte      = rx_byte;
    res.first_of_frame = 1'b0;
    res.last_of_frame  = 1'b0;
    res.trans_id       = hdr_new[47:32];
    res.frame_length   = len;
    res.error_code     = mbap_pkg::ERR_NONE;

    if (operation == mbap_pkg::OP_RESTART) begin
      byte_position_next = '0;
      header_store_next  = '0;
      closed_next        = 1'b0;
    end else if (!closed) begin
      if (in_header) begin
        header_store_next  = hdr_new;
        byte_position_next = pos_plus1[mbap_pkg::POS_W-1:0];
        if (hdr_done) begin
          res.kind      = mbap_pkg::KIND_ERROR;
          res.data_byte = 8'h00;
          priority if (prot_field != 16'h0000) begin
            res_valid      = 1'b1;
            res.error_code = mbap_pkg::ERR_PROTO_ID;
          end else if (len < 16'(mbap_pkg::MIN_LEN)) begin
            res_valid      = 1'b1;
            res.error_code = mbap_pkg::ERR_LEN_SHORT;
          end else if (frame_total > {1'b0, max_frame_bytes}) begin
            res_valid      = 1'b1;
            res.error_code = mbap_pkg::ERR_TOO_LARGE;
          end else begin
            res_valid = 1'b0;
          end
          closed_next = res_valid;
        end
      end else begin
        res_valid          = 1'b1;
        res.first_of_frame = byte_position == mbap_pkg::POS_W'(mbap_pkg::HDR_BYTES);
        res.last_of_frame  = last;
        byte_position_next = last ? '0 : pos_plus1[mbap_pkg::POS_W-1:0];
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= mbap_pkg::MAX_FRAME_RESET;
      byte_position   <= '0;
      header_store    <= '0;
      closed          <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_frame_bytes <= cfg_data;
      end
      if (in_fire) begin
        byte_position <= byte_position_next;
        header_store  <= header_store_next;
        closed        <= closed_next;
      end
    end
  end

endmodule

// File: sv/mbap_out_buf.sv
// Output register with a skid stage for the result channel.
module mbap_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  mbap_pkg::res_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output mbap_pkg::res_t pop_data,
  input  logic           pop_ready
);

  logic           out_valid;
  mbap_pkg::res_t out_data;
  logic           skid_valid;
  mbap_pkg::res_t skid_data;
  logic           push_fire;
  logic           out_free;

  assign push_ready = !skid_valid;
  assign push_fire  = push_valid && push_ready;
  assign out_free   = !out_valid || pop_ready;
  assign pop_valid  = out_valid;
  assign pop_data   = out_data;

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push_fire;
      skid_valid <= 1'b0;
    end else if (push_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push_fire) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: sv/mbap_request_deframer.sv
// Top level of the Modbus TCP MBAP request deframer.
//
// Input channel (in_valid/in_ready): one transaction per received TCP byte
// (operation = 0) or a connection restart (operation = 1). The six MBAP
// header bytes are captured and checked on the sixth byte; a bad header gives
// one error transaction and the parser drops bytes until a restart.
// Output channel (out_valid/out_ready): unit id and PDU bytes with the
// transaction id, length and first/last marks, or an error transaction.
// Config channel (cfg_valid/cfg_ready): writes max_frame_bytes; always ready,
// takes effect at the next header check.
// Throughput: one input byte per cycle while in_ready is high. A result is
// registered into the output register, or into the skid stage while that is held;
// the per-byte work is a counter and a few compares ahead of the output register.
// Stall: when the receiver holds out_ready low, one more result goes into the
// skid stage, then in_ready stays low until the receiver takes the output
// register; it rises again in the cycle after that transaction.
// Reset: position, header and closed flag clear, max_frame_bytes returns to
// 260, both output stages empty.
module mbap_request_deframer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mbap_pkg::MAX_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       kind,
  output logic [7:0]                 data_byte,
  output logic                       first_of_frame,
  output logic                       last_of_frame,
  output logic [15:0]                trans_id,
  output logic [15:0]                frame_length,
  output logic [1:0]                 error_code
);

  logic           in_fire;
  logic           res_valid;
  mbap_pkg::res_t res;
  mbap_pkg::res_t out_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Byte parser
  mbap_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .operation (operation),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register and skid stage
  mbap_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_fire && res_valid),
    .push_data  (res),
    .push_ready (in_ready),
    .pop_valid  (out_valid),
    .pop_data   (out_res),
    .pop_ready  (out_ready)
  );

  assign kind           = out_res.kind;
  assign data_byte      = out_res.data_byte;
  assign first_of_frame = out_res.first_of_frame;
  assign last_of_frame  = out_res.last_of_frame;
  assign trans_id       = out_res.trans_id;
  assign frame_length   = out_res.frame_length;
  assign error_code     = out_res.error_code;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the MBAP request deframer.
module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  // DUT inputs, known from time zero
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic [mbap_pkg::MAX_W-1:0] cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       operation = mbap_pkg::OP_BYTE;
  logic [7:0]                 rx_byte   = 8'd0;
  logic                       out_ready = 1'b0;

  // DUT outputs
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic        kind;
  logic [7:0]  data_byte;
  logic        first_of_frame;
  logic        last_of_frame;
  logic [15:0] trans_id;
  logic [15:0] frame_length;
  logic [1:0]  error_code;

  // Deframer state mirror, starts at the reset state
  logic [mbap_pkg::POS_W-1:0] frame_pos     = '0;
  logic [47:0]                header_bytes  = '0;
  logic                       parser_closed = 1'b0;
  logic [mbap_pkg::MAX_W-1:0] max_frame     = mbap_pkg::MAX_FRAME_RESET;

  mbap_pkg::res_t predicted_results[$];
  mbap_pkg::res_t got_result;
  mbap_pkg::res_t want_result;

  int mismatches   = 0;
  int sent_items   = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int cycle_count  = 0;

  // Long receiver hold-off: the test toggles hold_req, the receiver counts
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  mbap_request_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .trans_id       (trans_id),
    .frame_length   (frame_length),
    .error_code     (error_code)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Printable form of one result transaction
  function automatic string res_text(input mbap_pkg::res_t r);
    return $sformatf("kind=%0d data=%02h first=%0d last=%0d tid=%04h len=%04h err=%0d",
                     r.kind, r.data_byte, r.first_of_frame, r.last_of_frame,
                     r.trans_id, r.frame_length, r.error_code);
  endfunction

  // Advance the deframer mirror by one input transaction; returns 1 when it yields a result
  function automatic bit deframe_step(input logic op, input logic [7:0] b,
                                      output mbap_pkg::res_t res);
    logic [15:0] len;
    logic        is_last;
    res = '0;
    if (op == mbap_pkg::OP_RESTART) begin
      frame_pos     = '0;
      header_bytes  = '0;
      parser_closed = 1'b0;
      return 1'b0;
    end
    if (parser_closed) return 1'b0;

    // Header capture, checked on the sixth byte
    if (frame_pos < mbap_pkg::HDR_BYTES) begin
      header_bytes = {header_bytes[39:0], b};
      frame_pos    = frame_pos + 1'b1;
      if (frame_pos < mbap_pkg::HDR_BYTES) return 1'b0;
      len              = header_bytes[15:0];
      res.kind         = mbap_pkg::KIND_ERROR;
      res.trans_id     = header_bytes[47:32];
      res.frame_length = len;
      if (header_bytes[31:16] != 16'd0) res.error_code = mbap_pkg::ERR_PROTO_ID;
      else if (len < mbap_pkg::MIN_LEN) res.error_code = mbap_pkg::ERR_LEN_SHORT;
      else if (mbap_pkg::HDR_BYTES + len > max_frame)
        res.error_code = mbap_pkg::ERR_TOO_LARGE;
      else return 1'b0;
      parser_closed = 1'b1;
      return 1'b1;
    end

    // Unit id and PDU bytes
    len                = header_bytes[15:0];
    is_last            = (frame_pos + 1 >= mbap_pkg::HDR_BYTES + len);
    res.kind           = mbap_pkg::KIND_PAYLOAD;
    res.data_byte      = b;
    res.first_of_frame = (frame_pos == mbap_pkg::HDR_BYTES);
    res.last_of_frame  = is_last;
    res.trans_id       = header_bytes[47:32];
    res.frame_length   = len;
    res.error_code     = mbap_pkg::ERR_NONE;
    frame_pos = is_last ? '0 : frame_pos + 1'b1;
    return 1'b1;
  endfunction

  // Offer one input transaction, with an optional random gap ahead of it
  task automatic send_item(input logic op, input logic [7:0] b);
    mbap_pkg::res_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    rx_byte   <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    if (deframe_step(op, b, res)) predicted_results.insert(predicted_results.size(), res);
  endtask

  // MBAP header, big-endian fields
  task automatic send_header(input logic [15:0] tid, input logic [15:0] proto,
                             input logic [15:0] len);
    send_item(mbap_pkg::OP_BYTE, tid[15:8]);
    send_item(mbap_pkg::OP_BYTE, tid[7:0]);
    send_item(mbap_pkg::OP_BYTE, proto[15:8]);
    send_item(mbap_pkg::OP_BYTE, proto[7:0]);
    send_item(mbap_pkg::OP_BYTE, len[15:8]);
    send_item(mbap_pkg::OP_BYTE, len[7:0]);
  endtask

  // Stop offering input and wait until the output side has gone quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_frame(input logic [mbap_pkg::MAX_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_frame = value;
  endtask

  // One random sequence: mostly good frames, some bad headers, truncations and noise
  task automatic send_random_frame();
    int          pick;
    int          max_len;
    int          len;
    int          n;
    int          lo;
    logic [15:0] proto;
    max_len = (max_frame > 17'd65541) ? 65535 :
              int'(max_frame) - int'(mbap_pkg::HDR_BYTES);
    pick    = $urandom_range(99);
    if (pick < 70 && max_len >= 2) begin
      n = $urandom_range(99);
      if (n < 80) len = $urandom_range(2, (max_len < 10) ? max_len : 10);
      else if (n < 95) len = $urandom_range(2, (max_len < 300) ? max_len : 300);
      else len = max_len;
      send_header(16'($urandom), 16'd0, len[15:0]);
      // huge frames are cut short by a restart
      if (len > 300 || $urandom_range(99) < 6) begin
        repeat ($urandom_range(0, (len < 20) ? len - 1 : 20))
          send_item(mbap_pkg::OP_BYTE, 8'($urandom));
        send_item(mbap_pkg::OP_RESTART, 8'($urandom));
      end else begin
        repeat (len) send_item(mbap_pkg::OP_BYTE, 8'($urandom));
      end
    end else if (pick < 93) begin
      lo = int'(max_frame) - 5;
      if (lo < 2) lo = 2;
      if (pick < 82 || lo > 65535) begin
        proto = 16'($urandom_range(1, 65535));
        len   = $urandom_range(0, 65535);
      end else if (pick < 87) begin
        proto = 16'd0;
        len   = $urandom_range(0, 1);
      end else begin
        proto = 16'd0;
        len   = $urandom_range(1) ? lo : $urandom_range(lo, 65535);
      end
      send_header(16'($urandom), proto, len[15:0]);
      // bytes after the error are dropped
      repeat ($urandom_range(0, 3)) send_item(mbap_pkg::OP_BYTE, 8'($urandom));
      send_item(mbap_pkg::OP_RESTART, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8))
        send_item(($urandom_range(4) == 0) ? mbap_pkg::OP_RESTART : mbap_pkg::OP_BYTE,
                  8'($urandom));
      send_item(mbap_pkg::OP_RESTART, 8'($urandom));
    end
  endtask

  // Directed: protocol id checked ahead of length, closed parser, short length
  task automatic test_header_checks();
    send_header(16'hFFFF, 16'h8000, 16'h0000);
    send_item(mbap_pkg::OP_BYTE, 8'hFF);
    send_item(mbap_pkg::OP_RESTART, 8'hFF);
    send_header(16'h0000, 16'h0000, 16'h0001);
    send_item(mbap_pkg::OP_RESTART, 8'h00);
  endtask

  // Directed: frame exactly at the smallest limit, then one byte over
  task automatic test_frame_limit();
    write_max_frame(17'd8);
    send_header(16'h1234, 16'h0000, 16'h0002);
    send_item(mbap_pkg::OP_BYTE, 8'hFF);
    send_item(mbap_pkg::OP_BYTE, 8'h00);
    send_header(16'h8001, 16'h0000, 16'h0003);
    send_item(mbap_pkg::OP_RESTART, 8'h5A);
  endtask

  // Random streams under one idle profile, with the limit changed along the way
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int n_items);
    int stop_at;
    int seg_end;
    int pick;
    send_gap_pct = sender_pct;
    recv_gap_pct <= receiver_pct;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      pick = $urandom_range(9);
      unique case (pick)
        0:       write_max_frame(17'd8);
        1:       write_max_frame(17'd65541);
        2:       write_max_frame(mbap_pkg::MAX_FRAME_RESET);
        3:       write_max_frame(17'($urandom_range(0, 7)));
        4:       write_max_frame(17'($urandom_range(65542, 131071)));
        5:       write_max_frame(17'($urandom_range(8, 65541)));
        default: write_max_frame(17'($urandom_range(8, 400)));
      endcase
      seg_end = sent_items + 150;
      while (sent_items < seg_end && sent_items < stop_at) send_random_frame();
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming
  task automatic test_backpressure();
    write_max_frame(mbap_pkg::MAX_FRAME_RESET);
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    hold_req <= ~hold_req;
    repeat (3) begin
      send_header(16'($urandom), 16'd0, 16'd10);
      repeat (10) send_item(mbap_pkg::OP_BYTE, 8'($urandom));
    end
  endtask

  // Result checker and out_ready driver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result = '{kind, data_byte, first_of_frame, last_of_frame,
                     trans_id, frame_length, error_code};
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: %s", res_text(got_result));
      end else begin
        want_result = predicted_results[0];
        predicted_results.delete(0);
        if (got_result.kind !== want_result.kind ||
            got_result.data_byte !== want_result.data_byte ||
            got_result.first_of_frame !== want_result.first_of_frame ||
            got_result.last_of_frame !== want_result.last_of_frame ||
            got_result.trans_id !== want_result.trans_id ||
            got_result.frame_length !== want_result.frame_length ||
            got_result.error_code !== want_result.error_code) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch expected: %s", res_text(want_result));
            $display("mismatch actual:   %s", res_text(got_result));
          end
        end
      end
    end

    // Random stalls, or a long hold-off when requested
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mbap_request_deframer regression: fail");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_header_checks();
    test_frame_limit();
    test_random_traffic(11, 45, 630);
    test_backpressure();
    test_random_traffic(45, 11, 630);
    test_random_traffic(0, 0, 630);
    drain_results();
    if (mismatches == 0) begin
      $display("mbap_request_deframer regression: pass");
    end else begin
      $display("mbap_request_deframer regression: fail");
    end
    $finish;
  end

endmodule
